// ===== rtl/cnf_pkg.sv =====
package cnf_pkg;

    // default geometry and channel count
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CHANNELS_DEF   = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIM_W      = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd4;

    // arithmetic widths: 9 taps of 8-bit signed times 8-bit unsigned
    localparam int SUM_W     = 20;
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W    = 5;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic       load;
        logic       read;
        logic       write;
        logic       mac_clear;
        logic       mac_en;
        logic [1:0] tap_row;
        logic [1:0] tap_col;
        logic       div_load;
        logic       div_step;
        logic       done;
    } t_cmd;

    // status from the datapath
    typedef struct packed {
        logic drop;
        logic emit;
    } t_status;

endpackage

// ===== rtl/cnf_pix_if.sv =====
interface cnf_pix_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] pixel_ch0;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch2;
    logic [7:0] pixel_ch3;

    modport source (output valid, action, pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3,
                    input ready);
    modport sink (input valid, action, pixel_ch0, pixel_ch1, pixel_ch2, pixel_ch3,
                  output ready);
endinterface

// ===== rtl/cnf_res_if.sv =====
interface cnf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic [7:0] out_ch3;
    logic       frame_last;

    modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, frame_last,
                    input ready);
    modport sink (input valid, out_ch0, out_ch1, out_ch2, out_ch3, frame_last,
                  output ready);
endinterface

// ===== rtl/cnf_datapath.sv =====
module cnf_datapath #(
    parameter int MAX_WIDTH  = cnf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cnf_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNELS   = cnf_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cnf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cnf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_action,
    input  logic [31:0]                     i_pixel,
    input  cnf_pkg::t_cmd                   i_cmd,
    output cnf_pkg::t_status                o_status,
    output logic [31:0]                     o_result,
    output logic                            o_frame_last
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int ORW = $clog2(MAX_HEIGHT) + 1;
    localparam int IRW = $clog2(MAX_HEIGHT) + 2;
    localparam int SW  = cnf_pkg::SUM_W;
    localparam int MW  = cnf_pkg::MAG_W;

    // configuration registers
    logic [23:0]                  r_coef [3];
    logic [cnf_pkg::DIM_W-1:0]    r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= 24'h000000;
            r_coef[1] <= 24'h010000;
            r_coef[2] <= 24'h000000;
            r_width   <= cnf_pkg::DIM_W'(1024);
            r_height  <= cnf_pkg::DIM_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cnf_pkg::CFG_COEFF_TOP: r_coef[0] <= i_cfg_data;
                cnf_pkg::CFG_COEFF_MID: r_coef[1] <= i_cfg_data;
                cnf_pkg::CFG_COEFF_BOT: r_coef[2] <= i_cfg_data;
                cnf_pkg::CFG_WIDTH:     r_width   <= i_cfg_data[cnf_pkg::DIM_W-1:0];
                cnf_pkg::CFG_HEIGHT:    r_height  <= i_cfg_data[cnf_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry, clamped to 1..max
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    always_comb begin
        if (r_width == '0) w_eff = WW'(1);
        else if (32'(r_width) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
        else w_eff = WW'(32'(r_width));
        if (r_height == '0) h_eff = HW'(1);
        else if (32'(r_height) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
        else h_eff = HW'(32'(r_height));
    end

    // position counters
    logic [CW-1:0]  r_in_col, r_out_col;
    logic [IRW-1:0] r_in_row;
    logic [ORW-1:0] r_out_row;

    logic in_rows_open, in_col_wrap, out_col_wrap, out_row_end, last;
    assign in_rows_open = 32'(r_in_row) < 32'(h_eff);
    assign in_col_wrap  = 32'(r_in_col) + 32'd1 >= 32'(w_eff);
    assign out_col_wrap = 32'(r_out_col) + 32'd1 >= 32'(w_eff);
    assign out_row_end  = 32'(r_out_row) + 32'd1 >= 32'(h_eff);
    assign last         = out_row_end && out_col_wrap;

    assign o_status.drop = in_rows_open && i_action;
    assign o_status.emit = (32'(r_in_row) >= 32'd2) || (r_in_row == IRW'(1) && r_in_col != '0);
    assign o_frame_last  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cmd.done) begin
            if (last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if (out_col_wrap) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + ORW'(1);
            end else begin
                r_out_col <= r_out_col + CW'(1);
            end
        end else if (i_cmd.write) begin
            if (in_col_wrap) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + IRW'(1);
            end else begin
                r_in_col <= r_in_col + CW'(1);
            end
        end
    end

    // incoming pixel, unused channels and drain items give zero
    logic [31:0] r_pix;
    logic [31:0] pix_gated;
    always_comb begin
        pix_gated = '0;
        if (in_rows_open) begin
            for (int ch = 0; ch < 4; ch++) begin
                if (ch < CHANNELS) pix_gated[8*ch +: 8] = i_pixel[8*ch +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_pix <= pix_gated;
    end

    // line stores
    logic [31:0] mem_upper [MAX_WIDTH];
    logic [31:0] mem_lower [MAX_WIDTH];
    logic [31:0] r_top, r_mid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_top <= mem_upper[r_in_col];
            r_mid <= mem_lower[r_in_col];
        end
        if (i_cmd.write) begin
            mem_upper[r_in_col] <= r_mid;
            mem_lower[r_in_col] <= r_pix;
        end
    end

    // 3x3 window, new column enters on the right
    logic [31:0] r_win [9];
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= r_top;
            r_win[5] <= r_mid;
            r_win[8] <= r_pix;
        end
    end

    // tap selection and bounds
    logic [3:0]        tap_idx;
    logic [31:0]       tap_pix;
    logic signed [7:0] tap_k;
    logic              row_in, col_in, tap_in;
    always_comb begin
        tap_idx = 4'(i_cmd.tap_row) * 4'd3 + 4'(i_cmd.tap_col);
        tap_pix = r_win[tap_idx];
        tap_k   = r_coef[i_cmd.tap_row][8*i_cmd.tap_col +: 8];
        case (i_cmd.tap_row)
            2'd0:    row_in = r_out_row != '0;
            2'd1:    row_in = 32'(r_out_row) < 32'(h_eff);
            default: row_in = !out_row_end;
        endcase
        case (i_cmd.tap_col)
            2'd0:    col_in = r_out_col != '0;
            2'd1:    col_in = 32'(r_out_col) < 32'(w_eff);
            default: col_in = !out_col_wrap;
        endcase
        tap_in = row_in && col_in;
    end

    // multiply-accumulate, one tap a cycle on all channels
    logic signed [SW-1:0] r_acc [4];
    logic [3:0]           r_cnt;
    logic [MW-1:0]        r_quo [4];
    logic [4:0]           r_rem [4];
    logic                 r_neg [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int ch = 0; ch < 4; ch++) r_acc[ch] <= '0;
        end else if (i_cmd.mac_clear) begin
            r_cnt <= '0;
            for (int ch = 0; ch < 4; ch++) r_acc[ch] <= '0;
        end else if (i_cmd.mac_en && tap_in) begin
            if (tap_k != 8'sd0) r_cnt <= r_cnt + 4'd1;
            for (int ch = 0; ch < 4; ch++) begin
                r_acc[ch] <= r_acc[ch]
                    + SW'(tap_k * $signed({1'b0, tap_pix[8*ch +: 8]}));
            end
        end
    end

    // restoring divider, one quotient bit a cycle per channel
    logic [4:0] rem_try [4];
    always_comb begin
        for (int ch = 0; ch < 4; ch++) rem_try[ch] = {r_rem[ch][3:0], r_quo[ch][MW-1]};
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 4; ch++) begin
            if (i_cmd.div_load) begin
                r_quo[ch] <= r_acc[ch][MW-1:0];
                r_neg[ch] <= r_acc[ch][SW-1];
                r_rem[ch] <= '0;
            end else if (i_cmd.div_step) begin
                if (rem_try[ch] >= {1'b0, r_cnt}) begin
                    r_rem[ch] <= rem_try[ch] - {1'b0, r_cnt};
                    r_quo[ch] <= {r_quo[ch][MW-2:0], 1'b1};
                end else begin
                    r_rem[ch] <= rem_try[ch];
                    r_quo[ch] <= {r_quo[ch][MW-2:0], 1'b0};
                end
            end
        end
    end

    // clamp to 0..255, zero count gives zero
    always_comb begin
        o_result = '0;
        for (int ch = 0; ch < 4; ch++) begin
            if (ch < CHANNELS && r_cnt != '0 && !r_neg[ch]) begin
                if (r_quo[ch] > MW'(8'hFF)) o_result[8*ch +: 8] = 8'hFF;
                else o_result[8*ch +: 8] = r_quo[ch][7:0];
            end
        end
    end

    cnt_not_above_taps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'd9)
        else $error("tap count above nine");

    col_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> !$stable(r_in_col) || (r_in_col == '0))
        else $error("input column did not advance");

    frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.done && last) |=> (r_in_row == '0 && r_out_row == '0))
        else $error("frame end left counters set");

endmodule

// ===== rtl/cnf_ctrl.sv =====
module cnf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  cnf_pkg::t_status i_status,
    output cnf_pkg::t_cmd    o_cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_WRITE = 6'b000100,
        S_MAC   = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [1:0]                 r_tr, n_tr, r_tc, n_tc;
    logic [cnf_pkg::STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tr    <= '0;
            r_tc    <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_tr    <= n_tr;
            r_tc    <= n_tc;
            r_step  <= n_step;
        end
    end

    // sequencing of one word through read and update, then taps, divide and output if it gives a result
    always_comb begin
        n_state     = r_state;
        n_tr        = r_tr;
        n_tc        = r_tc;
        n_step      = r_step;
        o_cmd       = '0;
        o_cmd.tap_row = r_tr;
        o_cmd.tap_col = r_tc;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_status.drop) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write     = 1'b1;
                o_cmd.mac_clear = 1'b1;
                n_tr            = '0;
                n_tc            = '0;
                n_state         = i_status.emit ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                o_cmd.mac_en = 1'b1;
                if (r_tc == 2'd2) begin
                    n_tc = '0;
                    if (r_tr == 2'd2) begin
                        n_step  = '0;
                        n_state = S_DIV;
                    end else begin
                        n_tr = r_tr + 2'd1;
                    end
                end else begin
                    n_tc = r_tc + 2'd1;
                end
            end
            S_DIV: begin
                if (r_step == '0) o_cmd.div_load = 1'b1;
                else o_cmd.div_step = 1'b1;
                if (r_step == cnf_pkg::STEP_W'(cnf_pkg::DIV_STEPS)) n_state = S_OUT;
                else n_step = r_step + cnf_pkg::STEP_W'(1);
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_out_ready) |=> r_state == S_IDLE)
        else $error("result word taken but block not idle");

    write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> $past(r_state) == S_READ)
        else $error("line store update without read");

    taps_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tr != 2'd3 && r_tc != 2'd3)
        else $error("tap counter out of range");

    div_steps_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= cnf_pkg::STEP_W'(cnf_pkg::DIV_STEPS))
        else $error("divider step counter overran");

endmodule

// ===== rtl/conv3x3_nonzero_norm_filter.sv =====
// channel   dir  handshake      payload
// i_pix     in   valid/ready    action, pixel_ch0..pixel_ch3
// o_res     out  valid/ready    out_ch0..out_ch3, frame_last
// i_cfg_*   in   write enable   register index, 24-bit data
//
// one word at a time: a word with action set while input rows are open is
// only taken; other words pass the line store read and update, and a word with
// a result then the window taps on the shared multipliers, the divider and the output wait
// reset is synchronous on i_rst_n; the line stores are not cleared
// a stalled o_res holds the block until the result word is taken
module conv3x3_nonzero_norm_filter #(
    parameter int MAX_WIDTH  = cnf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cnf_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNELS   = cnf_pkg::CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cnf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cnf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cnf_pix_if.sink                        i_pix,
    cnf_res_if.source                      o_res
);
    cnf_pkg::t_cmd    cmd;
    cnf_pkg::t_status status;
    logic [31:0]      result;

    // sequencer
    cnf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // line stores, window, arithmetic
    cnf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CHANNELS   (CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_pix.action),
        .i_pixel      ({i_pix.pixel_ch3, i_pix.pixel_ch2, i_pix.pixel_ch1, i_pix.pixel_ch0}),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_result     (result),
        .o_frame_last (o_res.frame_last)
    );

    assign o_res.out_ch0 = result[7:0];
    assign o_res.out_ch1 = result[15:8];
    assign o_res.out_ch2 = result[23:16];
    assign o_res.out_ch3 = result[31:24];

endmodule
